@@ hdl/tqs_pkg.sv @@
// Package for the task ready queue scheduler.
// Holds sizes, status and action codes, the task table entry and its port struct.
// No dependencies.
`timescale 1ns / 1ps

package tqs_pkg;

   // Number of task slots and the widths that follow from it.
   localparam int MAX_TASKS = 16;
   localparam int TASK_AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int COUNT_W   = $clog2(MAX_TASKS + 1);

   // Field widths of the streams.
   localparam int ID_W    = 4;
   localparam int PRIO_W  = 8;
   localparam int KIND_W  = 2;
   localparam int ACT_W   = 2;
   localparam int ERR_W   = 2;

   // Reset value of the main task priority.
   localparam logic [PRIO_W-1:0] MAIN_PRIO_RESET = 8'd31;

   typedef logic [TASK_AW-1:0] task_idx_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [PRIO_W-1:0]  prio_type;

   typedef enum logic [2:0] {
      ST_UNUSED  = 3'd0,
      ST_RUNNING = 3'd1,
      ST_READY   = 3'd2,
      ST_BLOCKED = 3'd3,
      ST_HANGING = 3'd4,
      ST_WAITING = 3'd5
   } task_status_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_START   = 2'd0,
      ACT_YIELD   = 2'd1,
      ACT_BLOCK   = 2'd2,
      ACT_UNBLOCK = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BLOCKED = 2'd0,
      KIND_HANGING = 2'd1,
      KIND_WAITING = 2'd2,
      KIND_SPARE   = 2'd3
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK          = 2'd0,
      ERR_SLOT_USED   = 2'd1,
      ERR_QUEUE_EMPTY = 2'd2,
      ERR_NOT_BLOCKED = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_POP,
      S_NEW,
      S_DONE,
      S_CFG
   } sched_state_type;

   // One entry of the task table.
   typedef struct packed {
      task_status_type status;
      prio_type        prio;
      prio_type        ticks;
   } task_entry_type;

   // Access request to the task table: one read and one write a cycle.
   typedef struct packed {
      logic           rd_en;
      task_idx_type   rd_addr;
      logic           wr_en;
      task_idx_type   wr_addr;
      task_entry_type wr_data;
   } tbl_req_type;

endpackage

@@ hdl/tqs_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tqs_task_table.sv @@
// Task table: status, priority and slice of every task slot in one RAM.
// Depends on tqs_pkg and tqs_ram.
`timescale 1ns / 1ps

module tqs_task_table (
   input  logic                    clock,
   input  logic                    reset,
   input  tqs_pkg::tbl_req_type    tbl_req,
   input  tqs_pkg::prio_type       main_prio,
   output tqs_pkg::task_entry_type rd_entry
);

   logic [tqs_pkg::MAX_TASKS-1:0] vld_ff;
   logic [tqs_pkg::MAX_TASKS-1:0] vld_in;
   logic                          rd_vld_ff;
   logic                          rd_zero_ff;
   logic [$bits(tqs_pkg::task_entry_type)-1:0] ram_rd_data;
   tqs_pkg::task_entry_type       ram_entry;
   tqs_pkg::task_entry_type       reset_entry;

   tqs_ram #(
      .WIDTH ($bits(tqs_pkg::task_entry_type)),
      .DEPTH (tqs_pkg::MAX_TASKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (tbl_req.wr_en),
      .wr_addr (tbl_req.wr_addr),
      .wr_data (tbl_req.wr_data),
      .rd_en   (tbl_req.rd_en),
      .rd_addr (tbl_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // An entry becomes valid once it has been written.
   always_comb begin
      vld_in = vld_ff;
      if (tbl_req.wr_en) begin
         vld_in[tbl_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rd_zero_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (tbl_req.rd_en) begin
            rd_vld_ff  <= vld_ff[tbl_req.rd_addr];
            rd_zero_ff <= (tbl_req.rd_addr == '0);
         end
      end
   end

   // An entry never written reads as its reset value.
   always_comb begin
      ram_entry = tqs_pkg::task_entry_type'(ram_rd_data);
      if (rd_zero_ff) begin
         reset_entry = '{status: tqs_pkg::ST_RUNNING, prio: main_prio, ticks: main_prio};
      end else begin
         reset_entry = '{status: tqs_pkg::ST_UNUSED, prio: '0, ticks: '0};
      end
      rd_entry = rd_vld_ff ? ram_entry : reset_entry;
   end

endmodule

@@ hdl/task_ready_queue_scheduler_top.sv @@
// Top level of the task ready queue scheduler: event sequencer and ready ring.
// Depends on tqs_pkg, tqs_ram and tqs_task_table.
`timescale 1ns / 1ps

// Usage
// The req channel carries one scheduling event per word: start, yield, block or
// unblock. The rsp channel returns one word per event with the running task, its
// stored slice, the switch flag and an error code. The csr channel writes the
// main task priority, which also reloads slot 0 priority and slice.
// The response word is registered from state S_DONE: a block that meets an empty
// queue goes there straight from S_IDLE, start and unblock pass through S_CHECK,
// and yield and block pass through S_POP and S_NEW. One event is worked on at a
// time and a new one is taken once the previous has left the sequencer; a register
// write passes through S_CFG. The RAM reads are registered, which sets this order:
// start and unblock read the task entry before writing it back, while yield
// and block read the ring head and then the entry of the task they pop.
// After reset, task 0 is running with a slice of 31 and the ready queue is
// empty; no clearing pass is needed, so requests are taken at once.
// A response waiting on a stalled receiver stays in the output register; the
// next request is still accepted and worked on up to its own response, which
// then waits until the register frees.
module task_ready_queue_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // task_id[3:0], priority_req[11:4], block_kind[13:12], zero
   input  logic [1:0]  req_tuser,   // action[1:0]
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // running_task[3:0], running_ticks[11:4], switched[12],
                                    // error_code[14:13], zero[15]
   // Configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam tqs_pkg::task_idx_type IDX_LAST = tqs_pkg::task_idx_type'(tqs_pkg::MAX_TASKS - 1);

   tqs_pkg::sched_state_type state_ff, state_in;
   tqs_pkg::action_type      act_ff, act_in;
   logic [tqs_pkg::ID_W-1:0] id_ff, id_in;
   tqs_pkg::prio_type        prio_ff, prio_in;
   logic                     fwd_ff, fwd_in;
   logic                     sw_ff, sw_in;
   tqs_pkg::err_type         err_ff, err_in;
   tqs_pkg::prio_type        main_prio_ff, main_prio_in;
   tqs_pkg::task_idx_type    cur_ff, cur_in;
   tqs_pkg::prio_type        cur_prio_ff, cur_prio_in;
   tqs_pkg::prio_type        cur_ticks_ff, cur_ticks_in;
   tqs_pkg::task_idx_type    head_ff, head_in;
   tqs_pkg::task_idx_type    tail_ff, tail_in;
   tqs_pkg::count_type       count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_data_ff, rsp_data_in;

   tqs_pkg::tbl_req_type     tbl_req;
   tqs_pkg::task_entry_type  tbl_rd;

   logic                     ring_we;
   tqs_pkg::task_idx_type    ring_waddr;
   tqs_pkg::task_idx_type    ring_wdata;
   logic                     ring_re;
   tqs_pkg::task_idx_type    ring_rdata;

   tqs_pkg::task_idx_type    head_inc;
   tqs_pkg::task_idx_type    head_dec;
   tqs_pkg::task_idx_type    tail_inc;
   tqs_pkg::task_idx_type    id_idx;
   tqs_pkg::task_idx_type    new_task;
   logic                     id_oob;
   logic                     is_held;
   tqs_pkg::task_status_type blk_status;

   // Task table and ready ring.
   tqs_task_table u_table (
      .clock     (clock),
      .reset     (reset),
      .tbl_req   (tbl_req),
      .main_prio (main_prio_ff),
      .rd_entry  (tbl_rd)
   );

   tqs_ram #(
      .WIDTH (tqs_pkg::TASK_AW),
      .DEPTH (tqs_pkg::MAX_TASKS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (head_ff),
      .rd_data (ring_rdata)
   );

   // Ring pointer arithmetic, wrapping at the slot count.
   assign head_inc = (head_ff == IDX_LAST) ? '0 : head_ff + tqs_pkg::task_idx_type'(1);
   assign head_dec = (head_ff == '0) ? IDX_LAST : head_ff - tqs_pkg::task_idx_type'(1);
   assign tail_inc = (tail_ff == IDX_LAST) ? '0 : tail_ff + tqs_pkg::task_idx_type'(1);

   // Decoding of the captured request.
   assign id_idx   = tqs_pkg::task_idx_type'(id_ff);
   assign id_oob   = ({1'b0, id_ff} >= (tqs_pkg::ID_W + 1)'(tqs_pkg::MAX_TASKS));
   assign is_held  = (tbl_rd.status == tqs_pkg::ST_BLOCKED) ||
                     (tbl_rd.status == tqs_pkg::ST_HANGING) ||
                     (tbl_rd.status == tqs_pkg::ST_WAITING);
   assign new_task = fwd_ff ? cur_ff : ring_rdata;

   // Status left behind by a block, the spare kind counting as blocked.
   always_comb begin
      unique case (tqs_pkg::kind_type'(req_tdata[13:12]))
         tqs_pkg::KIND_HANGING: blk_status = tqs_pkg::ST_HANGING;
         tqs_pkg::KIND_WAITING: blk_status = tqs_pkg::ST_WAITING;
         default:               blk_status = tqs_pkg::ST_BLOCKED;
      endcase
   end

   // Handshakes: configuration wins over a request in the idle state.
   assign csr_ready  = (state_ff == tqs_pkg::S_IDLE);
   assign req_tready = (state_ff == tqs_pkg::S_IDLE) && !csr_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Event sequencer.
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      id_in        = id_ff;
      prio_in      = prio_ff;
      fwd_in       = fwd_ff;
      sw_in        = sw_ff;
      err_in       = err_ff;
      main_prio_in = main_prio_ff;
      cur_in       = cur_ff;
      cur_prio_in  = cur_prio_ff;
      cur_ticks_in = cur_ticks_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      tbl_req      = '0;
      ring_we      = 1'b0;
      ring_waddr   = tail_ff;
      ring_wdata   = cur_ff;
      ring_re      = 1'b0;

      unique case (state_ff)
         tqs_pkg::S_IDLE: begin
            if (csr_valid) begin
               // Register write, then read-modify-write of slot 0.
               main_prio_in    = csr_data;
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = '0;
               state_in        = tqs_pkg::S_CFG;
            end else if (req_tvalid) begin
               act_in  = tqs_pkg::action_type'(req_tuser);
               id_in   = req_tdata[3:0];
               prio_in = req_tdata[11:4];
               sw_in   = 1'b0;
               err_in  = tqs_pkg::ERR_OK;
               fwd_in  = 1'b0;
               unique case (tqs_pkg::action_type'(req_tuser))
                  tqs_pkg::ACT_START, tqs_pkg::ACT_UNBLOCK: begin
                     tbl_req.rd_en   = 1'b1;
                     tbl_req.rd_addr = tqs_pkg::task_idx_type'(req_tdata[3:0]);
                     state_in        = tqs_pkg::S_CHECK;
                  end
                  tqs_pkg::ACT_YIELD: begin
                     // Requeue the running task with a fresh slice, then pop.
                     tbl_req.wr_en   = 1'b1;
                     tbl_req.wr_addr = cur_ff;
                     tbl_req.wr_data = '{status: tqs_pkg::ST_READY,
                                         prio: cur_prio_ff, ticks: cur_prio_ff};
                     ring_we    = 1'b1;
                     ring_waddr = tail_ff;
                     ring_wdata = cur_ff;
                     ring_re    = 1'b1;
                     fwd_in     = (count_ff == '0);
                     tail_in    = tail_inc;
                     head_in    = head_inc;
                     state_in   = tqs_pkg::S_POP;
                  end
                  tqs_pkg::ACT_BLOCK: begin
                     if (count_ff == '0) begin
                        err_in   = tqs_pkg::ERR_QUEUE_EMPTY;
                        state_in = tqs_pkg::S_DONE;
                     end else begin
                        tbl_req.wr_en   = 1'b1;
                        tbl_req.wr_addr = cur_ff;
                        tbl_req.wr_data = '{status: blk_status,
                                            prio: cur_prio_ff, ticks: cur_ticks_ff};
                        ring_re  = 1'b1;
                        head_in  = head_inc;
                        count_in = count_ff - tqs_pkg::count_type'(1);
                        state_in = tqs_pkg::S_POP;
                     end
                  end
               endcase
            end
         end

         tqs_pkg::S_CHECK: begin
            unique case (act_ff)
               tqs_pkg::ACT_START: begin
                  if (id_oob || (tbl_rd.status != tqs_pkg::ST_UNUSED)) begin
                     err_in = tqs_pkg::ERR_SLOT_USED;
                  end else begin
                     tbl_req.wr_en   = 1'b1;
                     tbl_req.wr_addr = id_idx;
                     tbl_req.wr_data = '{status: tqs_pkg::ST_READY,
                                         prio: prio_ff, ticks: prio_ff};
                     ring_we    = 1'b1;
                     ring_waddr = tail_ff;
                     ring_wdata = id_idx;
                     tail_in    = tail_inc;
                     count_in   = count_ff + tqs_pkg::count_type'(1);
                  end
               end
               tqs_pkg::ACT_UNBLOCK: begin
                  if (id_oob || !is_held) begin
                     err_in = tqs_pkg::ERR_NOT_BLOCKED;
                  end else begin
                     // Ready again and placed at the front of the queue.
                     tbl_req.wr_en   = 1'b1;
                     tbl_req.wr_addr = id_idx;
                     tbl_req.wr_data = '{status: tqs_pkg::ST_READY,
                                         prio: tbl_rd.prio, ticks: tbl_rd.ticks};
                     ring_we    = 1'b1;
                     ring_waddr = head_dec;
                     ring_wdata = id_idx;
                     head_in    = head_dec;
                     count_in   = count_ff + tqs_pkg::count_type'(1);
                  end
               end
               default: begin
               end
            endcase
            state_in = tqs_pkg::S_DONE;
         end

         tqs_pkg::S_POP: begin
            // The popped task becomes current; fetch its entry.
            cur_in          = new_task;
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = new_task;
            state_in        = tqs_pkg::S_NEW;
         end

         tqs_pkg::S_NEW: begin
            cur_prio_in     = tbl_rd.prio;
            cur_ticks_in    = tbl_rd.ticks;
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = cur_ff;
            tbl_req.wr_data = '{status: tqs_pkg::ST_RUNNING,
                                prio: tbl_rd.prio, ticks: tbl_rd.ticks};
            sw_in           = 1'b1;
            state_in        = tqs_pkg::S_DONE;
         end

         tqs_pkg::S_DONE: begin
            // Hand the word over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, err_ff, sw_ff, cur_ticks_ff,
                               tqs_pkg::ID_W'(cur_ff)};
               state_in     = tqs_pkg::S_IDLE;
            end
         end

         tqs_pkg::S_CFG: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = '0;
            tbl_req.wr_data = '{status: tbl_rd.status,
                                prio: main_prio_ff, ticks: main_prio_ff};
            if (cur_ff == '0) begin
               cur_prio_in  = main_prio_ff;
               cur_ticks_in = main_prio_ff;
            end
            state_in = tqs_pkg::S_IDLE;
         end

         default: begin
            state_in = tqs_pkg::S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tqs_pkg::S_IDLE;
         main_prio_ff <= tqs_pkg::MAIN_PRIO_RESET;
         cur_ff       <= '0;
         cur_prio_ff  <= tqs_pkg::MAIN_PRIO_RESET;
         cur_ticks_ff <= tqs_pkg::MAIN_PRIO_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         sw_ff        <= 1'b0;
         err_ff       <= tqs_pkg::ERR_OK;
         act_ff       <= tqs_pkg::ACT_START;
      end else begin
         state_ff     <= state_in;
         main_prio_ff <= main_prio_in;
         cur_ff       <= cur_in;
         cur_prio_ff  <= cur_prio_in;
         cur_ticks_ff <= cur_ticks_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
         sw_ff        <= sw_in;
         err_ff       <= err_in;
         act_ff       <= act_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      prio_ff     <= prio_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ test/task_ready_queue_scheduler_top_tb.sv @@
// Self-checking testbench for the task ready queue scheduler top level.
// A clocked driver plays scheduling events from a queue, a clocked monitor checks each
// response word against a cycle-free scheduler model. Depends on tqs_pkg and the RTL.
`timescale 1ns / 1ps

module task_ready_queue_scheduler_top_tb;

   // One scheduling event as it travels on the request stream.
   typedef struct packed {
      tqs_pkg::action_type      act;
      logic [tqs_pkg::ID_W-1:0] id;
      tqs_pkg::prio_type        prio;
      tqs_pkg::kind_type        kind;
   } sched_event_type;

   // One response word split into its fields.
   typedef struct packed {
      logic [tqs_pkg::ID_W-1:0] task_no;
      tqs_pkg::prio_type        ticks;
      logic                     switched;
      tqs_pkg::err_type         err;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   // Stimulus and scoreboard stores.
   sched_event_type  pending_events[$];
   sched_result_type expected_results[$];
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               mismatches = 0;

   // Scheduler model state.
   tqs_pkg::prio_type        mdl_main_prio;
   tqs_pkg::task_status_type mdl_status[tqs_pkg::MAX_TASKS];
   tqs_pkg::prio_type        mdl_prio[tqs_pkg::MAX_TASKS];
   tqs_pkg::prio_type        mdl_ticks[tqs_pkg::MAX_TASKS];
   tqs_pkg::task_idx_type    mdl_ring[tqs_pkg::MAX_TASKS];
   int                       mdl_head;
   int                       mdl_tail;
   int                       mdl_count;
   tqs_pkg::task_idx_type    mdl_current;

   task_ready_queue_scheduler_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bring the model to its state after reset.
   task automatic reset_model();
      mdl_main_prio = tqs_pkg::MAIN_PRIO_RESET;
      for (int i = 0; i < tqs_pkg::MAX_TASKS; i++) begin
         mdl_status[i] = tqs_pkg::ST_UNUSED;
         mdl_prio[i]   = '0;
         mdl_ticks[i]  = '0;
         mdl_ring[i]   = '0;
      end
      mdl_status[0] = tqs_pkg::ST_RUNNING;
      mdl_prio[0]   = tqs_pkg::MAIN_PRIO_RESET;
      mdl_ticks[0]  = tqs_pkg::MAIN_PRIO_RESET;
      mdl_head      = 0;
      mdl_tail      = 0;
      mdl_count     = 0;
      mdl_current   = '0;
   endtask

   // A main priority write also reloads the priority and slice of slot 0.
   task automatic load_main_prio(tqs_pkg::prio_type value);
      mdl_main_prio = value;
      mdl_prio[0]   = value;
      mdl_ticks[0]  = value;
   endtask

   function automatic void ring_append(tqs_pkg::task_idx_type id);
      mdl_ring[mdl_tail] = id;
      mdl_tail  = (mdl_tail + 1) % tqs_pkg::MAX_TASKS;
      mdl_count = mdl_count + 1;
   endfunction

   // Pop the head of the ready ring and make it the running task.
   function automatic void dispatch_head();
      mdl_current = mdl_ring[mdl_head];
      mdl_head    = (mdl_head + 1) % tqs_pkg::MAX_TASKS;
      mdl_count   = mdl_count - 1;
      mdl_status[mdl_current] = tqs_pkg::ST_RUNNING;
   endfunction

   // Apply one event to the model and queue the response word it gives.
   function automatic void schedule_event(sched_event_type ev);
      sched_result_type      res;
      tqs_pkg::task_idx_type cur;
      tqs_pkg::task_idx_type slot;
      cur          = mdl_current;
      slot         = tqs_pkg::task_idx_type'(ev.id);
      res.switched = 1'b0;
      res.err      = tqs_pkg::ERR_OK;
      case (ev.act)
         tqs_pkg::ACT_START: begin
            if (int'(ev.id) >= tqs_pkg::MAX_TASKS ||
                mdl_status[slot] != tqs_pkg::ST_UNUSED) begin
               res.err = tqs_pkg::ERR_SLOT_USED;
            end else begin
               mdl_status[slot] = tqs_pkg::ST_READY;
               mdl_prio[slot]   = ev.prio;
               mdl_ticks[slot]  = ev.prio;
               ring_append(slot);
            end
         end
         tqs_pkg::ACT_YIELD: begin
            // The running task goes in before the pop, so the ring is never empty here.
            mdl_status[cur] = tqs_pkg::ST_READY;
            mdl_ticks[cur]  = mdl_prio[cur];
            ring_append(cur);
            dispatch_head();
            res.switched = 1'b1;
         end
         tqs_pkg::ACT_BLOCK: begin
            if (mdl_count == 0) begin
               res.err = tqs_pkg::ERR_QUEUE_EMPTY;
            end else begin
               case (ev.kind)
                  tqs_pkg::KIND_HANGING: mdl_status[cur] = tqs_pkg::ST_HANGING;
                  tqs_pkg::KIND_WAITING: mdl_status[cur] = tqs_pkg::ST_WAITING;
                  default:               mdl_status[cur] = tqs_pkg::ST_BLOCKED;
               endcase
               dispatch_head();
               res.switched = 1'b1;
            end
         end
         default: begin
            if (int'(ev.id) >= tqs_pkg::MAX_TASKS ||
                !(mdl_status[slot] == tqs_pkg::ST_BLOCKED ||
                  mdl_status[slot] == tqs_pkg::ST_HANGING ||
                  mdl_status[slot] == tqs_pkg::ST_WAITING)) begin
               res.err = tqs_pkg::ERR_NOT_BLOCKED;
            end else begin
               // An unblocked task goes to the front of the ring.
               mdl_status[slot] = tqs_pkg::ST_READY;
               mdl_head = (mdl_head + tqs_pkg::MAX_TASKS - 1) % tqs_pkg::MAX_TASKS;
               mdl_ring[mdl_head] = slot;
               mdl_count = mdl_count + 1;
            end
         end
      endcase
      res.task_no = tqs_pkg::ID_W'(mdl_current);
      res.ticks   = mdl_ticks[mdl_current];
      expected_results.push_back(res);
   endfunction

   function automatic sched_event_type make_event(tqs_pkg::action_type act, int id,
                                                  int prio, tqs_pkg::kind_type kind);
      sched_event_type ev;
      ev.act  = act;
      ev.id   = tqs_pkg::ID_W'(id);
      ev.prio = tqs_pkg::PRIO_W'(prio);
      ev.kind = kind;
      return ev;
   endfunction

   // Random event: a mix weighted towards yield, block and unblock so that the
   // ready ring keeps filling and draining.
   function automatic sched_event_type random_event();
      sched_event_type ev;
      int              pick;
      pick    = $urandom_range(0, 99);
      ev.id   = tqs_pkg::ID_W'($urandom_range(0, tqs_pkg::MAX_TASKS - 1));
      ev.prio = tqs_pkg::PRIO_W'($urandom_range(0, 255));
      ev.kind = tqs_pkg::kind_type'($urandom_range(0, 3));
      if (pick < 12)      ev.act = tqs_pkg::ACT_START;
      else if (pick < 42) ev.act = tqs_pkg::ACT_YIELD;
      else if (pick < 68) ev.act = tqs_pkg::ACT_BLOCK;
      else                ev.act = tqs_pkg::ACT_UNBLOCK;
      return ev;
   endfunction

   // Write the main priority register; only called while the block is idle.
   task automatic write_main_prio(tqs_pkg::prio_type value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      load_main_prio(value);
   endtask

   // Hold until every queued event has gone out and every response has come back,
   // then let the pipeline settle.
   task automatic wait_drained();
      while (pending_events.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_random_phase(int send_idle, int recv_stall, int count);
      @(negedge clock);
      send_idle_pct  = send_idle;
      recv_stall_pct = recv_stall;
      for (int i = 0; i < count; i++)
         pending_events.push_back(random_event());
      wait_drained();
   endtask

   // Request driver: a word is taken at an edge with tvalid and tready high.
   always @(posedge clock) begin
      sched_event_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            schedule_event(make_event(tqs_pkg::action_type'(req_tuser),
                                      int'(req_tdata[3:0]), int'(req_tdata[11:4]),
                                      tqs_pkg::kind_type'(req_tdata[13:12])));
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               ev = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= ev.act;
               req_tdata  <= {2'b00, ev.kind, ev.prio, ev.id};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response receiver stalls at random.
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Response monitor: each word is checked against the oldest expected result.
   always @(posedge clock) begin
      sched_result_type exp_res;
      sched_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.task_no  = rsp_tdata[3:0];
         got.ticks    = rsp_tdata[11:4];
         got.switched = rsp_tdata[12];
         got.err      = tqs_pkg::err_type'(rsp_tdata[14:13]);
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing expected: ", $realtime,
                        "task %0d ticks %0d sw %0d err %0d",
                        got.task_no, got.ticks, got.switched, got.err);
         end else begin
            exp_res = expected_results.pop_front();
            if (got.task_no != exp_res.task_no || got.ticks != exp_res.ticks ||
                got.switched != exp_res.switched || got.err != exp_res.err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: expected task %0d ticks %0d sw %0d err %0d, ",
                           $realtime, exp_res.task_no, exp_res.ticks,
                           exp_res.switched, exp_res.err,
                           "got task %0d ticks %0d sw %0d err %0d",
                           got.task_no, got.ticks, got.switched, got.err);
            end
         end
      end
   end

   // Main sequence: reset, a directed run, then random phases with different idling.
   initial begin
      reset_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed events at the reset priority, no idling.
      @(negedge clock);
      pending_events.push_back(make_event(tqs_pkg::ACT_BLOCK,   0, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_YIELD,   9, 77,  tqs_pkg::KIND_SPARE));
      pending_events.push_back(make_event(tqs_pkg::ACT_START,   15, 255, tqs_pkg::KIND_WAITING));
      pending_events.push_back(make_event(tqs_pkg::ACT_START,   1, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_START,   15, 7,  tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_START,   0, 200, tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_UNBLOCK, 5, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_UNBLOCK, 1, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_YIELD,   0, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_BLOCK,   3, 0,   tqs_pkg::KIND_SPARE));
      pending_events.push_back(make_event(tqs_pkg::ACT_BLOCK,   0, 0,   tqs_pkg::KIND_HANGING));
      pending_events.push_back(make_event(tqs_pkg::ACT_BLOCK,   0, 0,   tqs_pkg::KIND_WAITING));
      pending_events.push_back(make_event(tqs_pkg::ACT_UNBLOCK, 15, 0,  tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_UNBLOCK, 1, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_BLOCK,   0, 0,   tqs_pkg::KIND_WAITING));
      pending_events.push_back(make_event(tqs_pkg::ACT_UNBLOCK, 0, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_UNBLOCK, 0, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_YIELD,   0, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_START,   8, 170, tqs_pkg::KIND_HANGING));
      pending_events.push_back(make_event(tqs_pkg::ACT_START,   7, 85,  tqs_pkg::KIND_SPARE));
      pending_events.push_back(make_event(tqs_pkg::ACT_YIELD,   0, 0,   tqs_pkg::KIND_BLOCKED));
      pending_events.push_back(make_event(tqs_pkg::ACT_YIELD,   0, 0,   tqs_pkg::KIND_BLOCKED));
      wait_drained();

      write_main_prio(8'hFF);
      run_random_phase(0, 0, 390);
      write_main_prio(8'h00);
      run_random_phase(86, 0, 390);
      write_main_prio(tqs_pkg::PRIO_W'($urandom_range(1, 254)));
      run_random_phase(0, 86, 390);
      write_main_prio(8'h80);
      run_random_phase(34, 34, 390);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASS task_ready_queue_scheduler_top");
      end else begin
         $display("FAIL task_ready_queue_scheduler_top");
      end
      $finish;
   end

   // Watchdog in case the block stops answering.
   initial begin
      #3000000;
      $display("FAIL task_ready_queue_scheduler_top");
      $finish;
   end

endmodule

@@ files.f @@
hdl/tqs_pkg.sv
hdl/tqs_ram.sv
hdl/tqs_task_table.sv
hdl/task_ready_queue_scheduler_top.sv
test/task_ready_queue_scheduler_top_tb.sv
